### design/multiturn_angle_tracker_top_macros.svh
// Assertion shorthands for the angle tracker.
`ifndef MULTITURN_ANGLE_TRACKER_TOP_MACROS_SVH
`define MULTITURN_ANGLE_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define MAT_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mat: same-cycle check failed");

`define MAT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mat: next-cycle check failed");

`else

`define MAT_ASSERT_IMPL(label, pre, post)

`define MAT_ASSERT_NEXT(label, pre, post)

`endif

`endif

### design/mat_pkg.sv
package mat_pkg;

    localparam int AVG_SAMPLES_LOG2 = 6;

    localparam int RAW_W      = 14;
    localparam int FRAC_W     = 10;
    localparam int ANGLE_W    = FRAC_W + 1;
    localparam int TURN_W     = 6;
    localparam int POS_W      = TURN_W + FRAC_W;
    localparam int LEVEL_W    = 12;
    localparam int SUM_W      = LEVEL_W + AVG_SAMPLES_LOG2;
    localparam int CNT_W      = AVG_SAMPLES_LOG2;
    localparam int CODE_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int PRES_W     = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = POS_W + LEVEL_W + 2 * CODE_W + PRES_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL       = ANGLE_W'(1024);
    localparam logic [ANGLE_W-1:0] LAST_ANGLE_RESET = ANGLE_W'(512);
    localparam logic [CNT_W-1:0]   CNT_LAST         = '1;
    localparam logic [PRES_W-1:0]  DETECT_VALUE     = PRES_W'(170);

    localparam logic [FRAC_W-1:0]  WRAP_HIGH_RESET  = FRAC_W'(800);
    localparam logic [FRAC_W-1:0]  WRAP_LOW_RESET   = FRAC_W'(300);
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET  = LEVEL_W'(3720);
    localparam logic [CODE_W-1:0]  OFFSET_RESET     = CODE_W'(19);

    typedef enum logic [1:0] {
        OP_ANGLE = 2'd0,
        OP_ADC   = 2'd1,
        OP_UART  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_HIGH = 2'd0,
        CFG_WRAP_LOW  = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_OFFSET    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [FRAC_W-1:0]  wrap_high;
        logic [FRAC_W-1:0]  wrap_low;
        logic [LEVEL_W-1:0] threshold;
        logic [CODE_W-1:0]  offset;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] last_angle;
        logic [ANGLE_W-1:0] current_angle;
        logic [TURN_W-1:0]  turn_count;
        logic [ANGLE_W-1:0] calibration;
        logic [POS_W-1:0]   position;
        logic [SUM_W-1:0]   sample_sum;
        logic [CNT_W-1:0]   sample_count;
        logic [LEVEL_W-1:0] average;
        logic [CODE_W-1:0]  low_code;
        logic [BYTE_W-1:0]  high_code;
        logic [CODE_W-1:0]  prior_code;
        logic [CODE_W-1:0]  confirmed_code;
        logic [CODE_W-1:0]  shown_tool;
        logic               present;
    } state_t;

endpackage

### design/mat_core.sv
module mat_core
    import mat_pkg::*;
(
    input  state_t             st,
    input  cfg_t               cfg,
    input  op_t                op,
    input  logic [RAW_W-1:0]   data,
    output state_t             nxt
);

    logic [ANGLE_W-1:0] angle;
    logic               fwd_wrap;
    logic               bwd_wrap;
    logic [TURN_W-1:0]  turn_n;
    logic [ANGLE_W-1:0] cal_n;
    logic [SUM_W-1:0]   sum_n;
    logic [LEVEL_W-1:0] avg;
    logic [BYTE_W-1:0]  rx_byte;
    logic [CODE_W-1:0]  low_n;
    logic [BYTE_W-1:0]  high_n;

    assign angle    = ANGLE_FULL - {1'b0, data[RAW_W-1:RAW_W-FRAC_W]};
    assign fwd_wrap = (st.last_angle > {1'b0, cfg.wrap_high}) &&
                      (angle < {1'b0, cfg.wrap_low});
    assign bwd_wrap = (st.last_angle < {1'b0, cfg.wrap_low}) &&
                      (angle > {1'b0, cfg.wrap_high});

    assign sum_n   = st.sample_sum + SUM_W'(data[LEVEL_W-1:0]);
    assign avg     = sum_n[AVG_SAMPLES_LOG2 +: LEVEL_W];
    assign rx_byte = data[BYTE_W-1:0];

    always_comb
    begin
        turn_n = st.turn_count;
        cal_n  = st.calibration;
        priority if (fwd_wrap)
        begin
            turn_n = st.turn_count + TURN_W'(1);
        end
        else if (bwd_wrap)
        begin
            if (st.turn_count != '0)
                turn_n = st.turn_count - TURN_W'(1);
            else
                cal_n = angle;
        end
        else
        begin
            turn_n = st.turn_count;
        end
        // at turn zero the calibration tracks the minimum angle
        if (cal_n > angle && turn_n == '0)
            cal_n = angle;
    end

    always_comb
    begin
        low_n  = st.low_code;
        high_n = st.high_code;
        if (rx_byte[BYTE_W-1])
            high_n = rx_byte;
        else
            low_n = rx_byte[CODE_W-1:0];
    end

    always_comb
    begin
        nxt = st;
        unique case (op)
            OP_ANGLE:
            begin
                nxt.last_angle    = angle;
                nxt.current_angle = angle;
                nxt.turn_count    = turn_n;
                nxt.calibration   = cal_n;
                nxt.position      = ({turn_n, {FRAC_W{1'b0}}} | POS_W'(angle))
                                    - POS_W'(cal_n);
            end
            OP_ADC:
            begin
                if (st.sample_count == CNT_LAST)
                begin
                    nxt.sample_count = '0;
                    nxt.sample_sum   = '0;
                    nxt.average      = avg;
                    if (avg < cfg.threshold)
                    begin
                        // tool removed
                        nxt.calibration = st.current_angle;
                        nxt.position    = '0;
                        nxt.turn_count  = '0;
                        nxt.shown_tool  = '0;
                    end
                    else if (st.shown_tool == '0 && st.confirmed_code > cfg.offset)
                    begin
                        nxt.shown_tool = st.confirmed_code - cfg.offset;
                    end
                end
                else
                begin
                    nxt.sample_count = st.sample_count + CNT_W'(1);
                    nxt.sample_sum   = sum_n;
                end
            end
            OP_UART:
            begin
                nxt.low_code  = low_n;
                nxt.high_code = high_n;
                if ({1'b0, low_n} == ~high_n)
                begin
                    if (st.prior_code == low_n)
                    begin
                        nxt.confirmed_code = low_n;
                        nxt.present        = 1'b1;
                    end
                    nxt.prior_code = low_n;
                end
            end
            OP_NONE:
            begin
                nxt = st;
            end
        endcase
    end

endmodule

### design/multiturn_angle_tracker_top.sv
// Multi-turn angle tracker with tool presence and tool code detection.
// Input stream: one beat per item; tuser carries the kind (angle sample,
// ADC sample or UART byte), tdata the raw value. Every input beat yields
// exactly one output beat carrying position, level average, confirmed tool
// code, displayed tool and presence count.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the wrap thresholds,
// presence threshold and tool offset; write only while the block is idle.
// Pipeline: input register, then result register. Throughput: one beat
// per cycle while the receiver keeps tready high; the state update is a
// single pass of compare/add logic between the input and result registers.
// Stall: with the receiver holding tready low, one further beat is taken
// into the input register, after which s_axis_tready drops until the
// result register is drained.
// Reset: asynchronous, active low; clears all state but last_angle (set to
// its reset value), restores the register defaults and empties both stages.
`include "multiturn_angle_tracker_top_macros.svh"

module multiturn_angle_tracker_top
    import mat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [13:0] data, [15:14] zero
    input  logic [1:0]            s_axis_tuser,   // [1:0] op

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] position, [27:16] level_average, [34:28] instrument_code,
    // [41:35] displayed_instrument, [49:42] presence_count, [55:50] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    op_t                   s1_op_reg;
    logic [RAW_W-1:0]      s1_data_reg;

    state_t                state_reg;
    state_t                state_next;
    cfg_t                  cfg_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                  out_ready;
    logic                  s1_move;
    logic                  s_accept;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && out_ready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign s1_valid_next  = s_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    mat_core u_core
    (
        .st   (state_reg),
        .cfg  (cfg_reg),
        .op   (s1_op_reg),
        .data (s1_data_reg),
        .nxt  (state_next)
    );

    assign out_data_next = {
        {(OUT_DATA_W - OUT_W){1'b0}},
        (state_next.present ? DETECT_VALUE : {PRES_W{1'b0}}),
        state_next.shown_tool,
        state_next.confirmed_code,
        state_next.average,
        state_next.position
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_op_reg     <= OP_NONE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s_accept)
                s1_op_reg <= op_t'(s_axis_tuser);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            s1_data_reg <= s_axis_tdata[RAW_W-1:0];
        if (s1_move)
            out_data_reg <= out_data_next;
    end

    // last_angle is the top field of the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= state_t'({LAST_ANGLE_RESET, {($bits(state_t) - ANGLE_W){1'b0}}});
        end
        else if (s1_move)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wrap_high <= WRAP_HIGH_RESET;
            cfg_reg.wrap_low  <= WRAP_LOW_RESET;
            cfg_reg.threshold <= THRESHOLD_RESET;
            cfg_reg.offset    <= OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WRAP_HIGH: cfg_reg.wrap_high <= cfg_data[FRAC_W-1:0];
                CFG_WRAP_LOW:  cfg_reg.wrap_low  <= cfg_data[FRAC_W-1:0];
                CFG_THRESHOLD: cfg_reg.threshold <= cfg_data[LEVEL_W-1:0];
                CFG_OFFSET:    cfg_reg.offset    <= cfg_data[CODE_W-1:0];
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `MAT_ASSERT_IMPL(a_cal_below_angle,
        state_reg.turn_count == '0,
        state_reg.calibration <= state_reg.current_angle)
    `MAT_ASSERT_NEXT(a_block_restart,
        s1_move && s1_op_reg == OP_ADC && state_reg.sample_count == CNT_LAST,
        state_reg.sample_count == '0 && state_reg.sample_sum == '0)
    `MAT_ASSERT_NEXT(a_move_fills_out, s1_move, out_valid_reg)
    `MAT_ASSERT_NEXT(a_stall_holds_state, !out_ready, $stable(state_reg))

endmodule

### tb/sv/tracker_checker.sv
module tracker_checker
    import mat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // [13:0] data, [15:14] zero
    input  logic [1:0]            s_axis_tuser,   // [1:0] op
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] position, [27:16] level_average, [34:28] instrument_code,
    // [41:35] displayed_instrument, [49:42] presence_count, [55:50] zero
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    mismatches,
    output int                    readings_due
);

    // lowest field last
    typedef struct packed {
        logic [PRES_W-1:0]  presence;
        logic [CODE_W-1:0]  shown;
        logic [CODE_W-1:0]  code;
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   position;
    } reading_t;

    logic [FRAC_W-1:0]  wrap_top;
    logic [FRAC_W-1:0]  wrap_bottom;
    logic [LEVEL_W-1:0] level_floor;
    logic [CODE_W-1:0]  tool_offset;

    logic [ANGLE_W-1:0] prev_angle;
    logic [ANGLE_W-1:0] angle_now;
    logic [TURN_W-1:0]  turns;
    logic [ANGLE_W-1:0] zero_point;
    logic [POS_W-1:0]   position;
    logic [SUM_W-1:0]   level_sum;
    logic [CNT_W:0]     level_samples;
    logic [LEVEL_W-1:0] level_mean;
    logic [BYTE_W-1:0]  code_low;
    logic [BYTE_W-1:0]  code_high;
    logic [BYTE_W-1:0]  code_seen;
    logic [BYTE_W-1:0]  code_confirmed;
    logic [CODE_W-1:0]  tool_shown;
    logic [PRES_W-1:0]  presence;

    reading_t expected_readings[$];
    reading_t seen;
    reading_t due;

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: %s got %0d expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    function automatic reading_t track_item(op_t op, logic [RAW_W-1:0] value);
        logic [ANGLE_W-1:0] angle;
        logic [BYTE_W-1:0]  rx_byte;
        case (op)
            OP_ANGLE:
            begin
                angle = ANGLE_FULL - ANGLE_W'(value[RAW_W-1:4]);
                if (prev_angle > wrap_top && angle < wrap_bottom)
                    turns = turns + 1'b1;
                else if (prev_angle < wrap_bottom && angle > wrap_top)
                begin
                    if (turns != '0)
                        turns = turns - 1'b1;
                    else
                        zero_point = angle;
                end
                prev_angle = angle;
                angle_now  = angle;
                if (zero_point > angle && turns == '0)
                    zero_point = angle;
                position = (POS_W'(angle) | {turns, {FRAC_W{1'b0}}}) - POS_W'(zero_point);
            end
            OP_ADC:
            begin
                level_samples = level_samples + 1'b1;
                level_sum     = level_sum + SUM_W'(value[LEVEL_W-1:0]);
                if (level_samples >= (1 << AVG_SAMPLES_LOG2))
                begin
                    level_samples = '0;
                    level_mean    = LEVEL_W'(level_sum >> AVG_SAMPLES_LOG2);
                    level_sum     = '0;
                    if (level_mean < level_floor)
                    begin
                        zero_point = angle_now;
                        position   = '0;
                        turns      = '0;
                        tool_shown = '0;
                    end
                    else if (tool_shown == '0 && code_confirmed > BYTE_W'(tool_offset))
                        tool_shown = CODE_W'(code_confirmed - BYTE_W'(tool_offset));
                end
            end
            OP_UART:
            begin
                rx_byte = value[BYTE_W-1:0];
                if (rx_byte[BYTE_W-1])
                    code_high = rx_byte;
                else
                    code_low = rx_byte;
                // complementary pair; confirmed on the second matching pair
                if (code_low == ~code_high)
                begin
                    if (code_seen == code_low)
                    begin
                        code_confirmed = code_low;
                        presence       = DETECT_VALUE;
                    end
                    code_seen = code_low;
                end
            end
            default: ;
        endcase
        return {presence, tool_shown, code_confirmed[CODE_W-1:0], level_mean, position};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_top       = WRAP_HIGH_RESET;
            wrap_bottom    = WRAP_LOW_RESET;
            level_floor    = THRESHOLD_RESET;
            tool_offset    = OFFSET_RESET;
            prev_angle     = LAST_ANGLE_RESET;
            angle_now      = '0;
            turns          = '0;
            zero_point     = '0;
            position       = '0;
            level_sum      = '0;
            level_samples  = '0;
            level_mean     = '0;
            code_low       = '0;
            code_high      = '0;
            code_seen      = '0;
            code_confirmed = '0;
            tool_shown     = '0;
            presence       = '0;
            expected_readings.delete();
            readings_due <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WRAP_HIGH: wrap_top    = cfg_data[FRAC_W-1:0];
                    CFG_WRAP_LOW:  wrap_bottom = cfg_data[FRAC_W-1:0];
                    CFG_THRESHOLD: level_floor = cfg_data[LEVEL_W-1:0];
                    CFG_OFFSET:    tool_offset = cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[$bits(reading_t)-1:0];
                if (expected_readings.size() == 0)
                    report_mismatch("unrequested beat, position", seen.position, 0);
                else
                begin
                    due = expected_readings.pop_front();
                    if (seen.position != due.position)
                        report_mismatch("position", seen.position, due.position);
                    if (seen.level != due.level)
                        report_mismatch("level_average", seen.level, due.level);
                    if (seen.code != due.code)
                        report_mismatch("instrument_code", seen.code, due.code);
                    if (seen.shown != due.shown)
                        report_mismatch("displayed_instrument", seen.shown, due.shown);
                    if (seen.presence != due.presence)
                        report_mismatch("presence_count", seen.presence, due.presence);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(track_item(op_t'(s_axis_tuser),
                                                       s_axis_tdata[RAW_W-1:0]));
            readings_due <= expected_readings.size();
        end
    end

endmodule

### tb/sv/tb_multiturn_angle_tracker_top.sv
module tb_multiturn_angle_tracker_top;
    import mat_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SPIN_ITEMS  = 320;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int mismatches;
    int readings_due;
    int quiet_cycles;
    int items_sent;
    int hold_left;
    int stall_left;
    int run_left;
    bit steady;
    bit hold_req;

    logic [RAW_W-1:0]   shaft;
    logic [LEVEL_W-1:0] floor_now;
    logic [CODE_W-1:0]  offset_now;

    multiturn_angle_tracker_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tracker_checker u_tracker_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .readings_due  (readings_due)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && run_left == 0)
                begin
                    stall_left = idle_len();
                    run_left   = $urandom_range(1, 8);
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    run_left--;
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_beat(op_t op, logic [RAW_W-1:0] value);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // raw going down turns the reversed angle up, so turns count up
    task automatic spin(int n, int step, bit raw_up);
        int k;
        int delta;
        for (k = 0; k < n; k++)
        begin
            delta = step + $urandom_range(0, step / 4) - step / 8;
            if ($urandom_range(0, 99) < 5)
                shaft = RAW_W'($urandom);
            else if (raw_up)
                shaft = shaft + RAW_W'(delta);
            else
                shaft = shaft - RAW_W'(delta);
            send_beat(OP_ANGLE, shaft);
        end
    endtask

    task automatic level_block();
        int mode;
        int level;
        int s;
        int k;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            level = $urandom_range(floor_now, 4095);
        else if (mode < 8)
            level = (floor_now == 0) ? 0 : $urandom_range(0, floor_now - 1);
        else
            level = -1;
        for (k = 0; k < (1 << AVG_SAMPLES_LOG2); k++)
        begin
            if ($urandom_range(0, 99) < 10)
                spin(1, 300, 1'($urandom_range(0, 1)));
            if (level < 0)
                s = $urandom_range(0, 4095);
            else
            begin
                s = level + $urandom_range(0, 16) - 8;
                if (s < 0)
                    s = 0;
                if (s > 4095)
                    s = 4095;
            end
            send_beat(OP_ADC, {2'($urandom), 12'(s)});
        end
    endtask

    task automatic code_burst();
        logic [BYTE_W-1:0] code;
        int reps;
        int k;
        int j;
        bit high_first;
        if (offset_now < 127 && $urandom_range(0, 1))
            code = BYTE_W'($urandom_range(offset_now + 1, 127));
        else
            code = BYTE_W'($urandom_range(0, 127));
        reps       = $urandom_range(1, 3);
        high_first = 1'($urandom_range(0, 1));
        for (k = 0; k < reps; k++)
        begin
            if ($urandom_range(0, 99) < 15)
                send_beat(OP_UART, RAW_W'($urandom));
            for (j = 0; j < 2; j++)
                send_beat(OP_UART, {6'($urandom), (j[0] ^ high_first) ? ~code : code});
        end
    endtask

    task automatic random_phase(int count);
        int goal;
        int kind;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                steady = ~steady;
            kind = $urandom_range(0, 99);
            if (kind < 35)
                spin($urandom_range(4, 60), $urandom_range(16, 6000),
                     1'($urandom_range(0, 1)));
            else if (kind < 55)
                level_block();
            else if (kind < 85)
                code_burst();
            else
                send_beat(op_t'($urandom_range(0, 3)), RAW_W'($urandom));
        end
        steady = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(logic [FRAC_W-1:0] wrap_hi, logic [FRAC_W-1:0] wrap_lo,
                                 logic [LEVEL_W-1:0] level_min, logic [CODE_W-1:0] offset);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WRAP_HIGH;
        cfg_data  <= CFG_W'(wrap_hi);
        @(posedge clk);
        cfg_index <= CFG_WRAP_LOW;
        cfg_data  <= CFG_W'(wrap_lo);
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_W'(level_min);
        @(posedge clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= CFG_W'(offset);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        floor_now  = level_min;
        offset_now = offset;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ANGLE;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_WRAP_HIGH;
        cfg_data      = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        shaft         = '0;
        floor_now     = THRESHOLD_RESET;
        offset_now    = OFFSET_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // raw zero gives the full-scale angle; turn up, down, then recapture at zero
        send_beat(OP_ANGLE, 14'd0);
        send_beat(OP_ANGLE, 14'h3FFF);
        send_beat(OP_ANGLE, 14'd8000);
        send_beat(OP_ANGLE, 14'd14000);
        send_beat(OP_ANGLE, 14'd1000);
        send_beat(OP_ANGLE, 14'd14000);
        send_beat(OP_ANGLE, 14'd1000);
        send_beat(OP_ANGLE, 14'd6784);
        send_beat(OP_ANGLE, 14'd13184);
        send_beat(OP_ANGLE, 14'd1984);
        send_beat(OP_ADC, 14'h3FFF);
        send_beat(OP_ADC, 14'd0);
        // code 0 confirmed straight after reset, then 0x2A, then extreme bytes
        send_beat(OP_UART, 14'h3FFF);
        send_beat(OP_UART, 14'h3F2A);
        send_beat(OP_UART, 14'h00D5);
        send_beat(OP_UART, 14'h1A2A);
        send_beat(OP_UART, 14'h0080);
        send_beat(OP_UART, 14'h007F);
        send_beat(OP_NONE, 14'h3FFF);

        random_phase(200);
        // long one-way spin, enough turns to wrap the turn counter
        spin(SPIN_ITEMS, 4000, 1'b0);

        steady   = 1'b1;
        hold_req = 1'b1;
        repeat (12) send_beat(OP_ANGLE, RAW_W'($urandom));
        steady = 1'b0;
        drain();

        set_registers(10'd1023, 10'd0, 12'd0, 7'd0);
        random_phase(230);
        drain();

        set_registers(10'd0, 10'd1023, 12'd4095, 7'd127);
        random_phase(230);
        drain();

        repeat (2)
        begin
            set_registers(FRAC_W'($urandom_range(500, 1023)), FRAC_W'($urandom_range(0, 500)),
                          LEVEL_W'($urandom_range(3000, 4095)),
                          CODE_W'($urandom_range(0, 60)));
            random_phase(230);
            drain();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/mat_pkg.sv
design/mat_core.sv
design/multiturn_angle_tracker_top.sv
tb/sv/tracker_checker.sv
tb/sv/tb_multiturn_angle_tracker_top.sv
